@@ hdl/wfbr_pkg.sv @@
// ----------------------------------------------------------------------------
// wfbr_pkg: shared definitions for the windowed flow byte ranker
// Sizes, field widths, result status codes and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package wfbr_pkg;

  localparam int FLOW_ENTRIES = 256;
  localparam int HIST_DEPTH   = 4096;
  localparam int TOP_N        = 5;

  localparam int FAW = $clog2(FLOW_ENTRIES);
  localparam int HAW = $clog2(HIST_DEPTH);
  localparam int TIW = (TOP_N > 1) ? $clog2(TOP_N) : 1;
  localparam int TN_PAD = 2 ** TIW;

  localparam int KEY_W  = 312;
  localparam int LEN_W  = 16;
  localparam int TIME_W = 48;
  localparam int TOT_W  = 32;
  localparam int WIN_W  = 32;
  localparam int IN_W   = 376;
  localparam int OUT_W  = 352;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd500000;

  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-1:0] ADDR_WINDOW = 3'd0;

  typedef enum logic [1:0] {
    ST_COUNTED   = 2'd0,
    ST_REPORT    = 2'd1,
    ST_FLOW_FULL = 2'd2,
    ST_HIST_FULL = 2'd3
  } status_e;

  typedef struct packed {
    logic latch_in;
    logic age_ret;
    logic age_sub;
    logic sort_start;
    logic pack_run;
    logic sort_run;
    logic sort_fin;
    logic srch_start;
    logic srch_run;
    logic decide;
    logic add;
    logic rank_start;
    logic rank_run;
    logic out_load;
    logic rep_out;
  } wfbr_cmd_t;

  typedef struct packed {
    logic hist_empty;
    logic age_expired;
    logic ret_valid;
    logic sort_done;
    logic srch_done;
    logic refused;
    logic counted;
    logic rank_done;
    logic rep_empty;
    logic rep_last;
    logic out_free;
  } wfbr_sts_t;

endpackage

`default_nettype wire

@@ hdl/wfbr_ram.sv @@
// ----------------------------------------------------------------------------
// wfbr_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module wfbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ hdl/wfbr_ctrl.sv @@
// ----------------------------------------------------------------------------
// wfbr_ctrl: sequencing state machine
// Steps one item through aging, list packing, key lookup, accounting,
// re-ranking and result hand-off, or through the report walk.
// ----------------------------------------------------------------------------
`default_nettype none

module wfbr_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_report_i,
  output logic                     in_ready_o,
  input  wire wfbr_pkg::wfbr_sts_t sts_i,
  output wfbr_pkg::wfbr_cmd_t      cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_AGE_RD  = 13'b0000000000010,
    S_AGE_CHK = 13'b0000000000100,
    S_AGE_SUB = 13'b0000000001000,
    S_PACK    = 13'b0000000010000,
    S_SRCH    = 13'b0000000100000,
    S_DECIDE  = 13'b0000001000000,
    S_ADD     = 13'b0000010000000,
    S_SORT    = 13'b0000100000000,
    S_RANK    = 13'b0001000000000,
    S_OUT     = 13'b0010000000000,
    S_REP_RD  = 13'b0100000000000,
    S_REP_OUT = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = in_report_i ? S_REP_RD : S_AGE_RD;
        end
      end
      S_AGE_RD: begin
        if (sts_i.hist_empty) begin
          cmd_o.sort_start = 1'b1;
          state_d = S_PACK;
        end else begin
          state_d = S_AGE_CHK;
        end
      end
      S_AGE_CHK: begin
        if (sts_i.age_expired) begin
          cmd_o.age_ret = 1'b1;
          state_d = sts_i.ret_valid ? S_AGE_SUB : S_AGE_RD;
        end else begin
          cmd_o.sort_start = 1'b1;
          state_d = S_PACK;
        end
      end
      S_AGE_SUB: begin
        cmd_o.age_sub = 1'b1;
        state_d = S_AGE_RD;
      end
      S_PACK: begin
        cmd_o.pack_run = 1'b1;
        if (sts_i.sort_done) begin
          cmd_o.sort_fin   = 1'b1;
          cmd_o.srch_start = 1'b1;
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        cmd_o.srch_run = 1'b1;
        if (sts_i.srch_done) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (sts_i.refused) begin
          cmd_o.sort_start = 1'b1;
          state_d = S_SORT;
        end else begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.add        = 1'b1;
        cmd_o.sort_start = 1'b1;
        state_d = S_SORT;
      end
      S_SORT: begin
        cmd_o.sort_run = 1'b1;
        if (sts_i.sort_done) begin
          cmd_o.sort_fin = 1'b1;
          if (sts_i.counted) begin
            cmd_o.rank_start = 1'b1;
            state_d = S_RANK;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_RANK: begin
        cmd_o.rank_run = 1'b1;
        if (sts_i.rank_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_REP_RD: begin
        state_d = sts_i.rep_empty ? S_IDLE : S_REP_OUT;
      end
      S_REP_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.rep_out = 1'b1;
          state_d = sts_i.rep_last ? S_IDLE : S_REP_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/wfbr_dp.sv @@
// ----------------------------------------------------------------------------
// wfbr_dp: datapath of the flow byte ranker
// History ring, flow key and total memories, the ranked row of cells with
// its odd-even transposition network, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wfbr_dp (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic [wfbr_pkg::WIN_W-1:0]            window_i,
  input  wire logic [wfbr_pkg::IN_W-1:0]             in_data_i,
  input  wire logic                                  in_report_i,
  input  wire wfbr_pkg::wfbr_cmd_t                   cmd_i,
  output wfbr_pkg::wfbr_sts_t                        sts_o,
  input  wire logic                                  out_ready_i,
  output logic                                       out_valid_o,
  output logic      [wfbr_pkg::OUT_W-1:0]            out_data_o,
  output logic      [1:0]                            out_user_o,
  output logic                                       out_last_o
);

  localparam int FE  = wfbr_pkg::FLOW_ENTRIES;
  localparam int FAW = wfbr_pkg::FAW;
  localparam int HAW = wfbr_pkg::HAW;
  localparam int TIW = wfbr_pkg::TIW;
  localparam int TNP = wfbr_pkg::TN_PAD;
  localparam int KW  = wfbr_pkg::KEY_W;
  localparam int LW  = wfbr_pkg::LEN_W;
  localparam int TW  = wfbr_pkg::TIME_W;
  localparam int SW  = wfbr_pkg::TOT_W;

  // Latched item.
  logic [KW-1:0] key_q;
  logic [LW-1:0] len_q;
  logic [TW-1:0] t_q;
  logic          rep_mode_q;

  // History ring.
  logic [HAW-1:0]    head_q;
  logic [HAW:0]      hcnt_q;
  logic [TW-1:0]     ht_rd;
  logic [FAW+LW-1:0] hs_rd;
  logic [FAW-1:0]    ret_slot_rd;
  logic [LW-1:0]     ret_len_rd;
  logic [FAW-1:0]    ret_slot_q;
  logic [LW-1:0]     ret_len_q;
  logic [TW-1:0]     age_diff;
  logic              hist_full;
  logic              hist_we;
  logic [HAW-1:0]    tail;

  // Flow tables.
  logic [FE-1:0]  valid_q;
  logic [FAW:0]   live_q;
  logic [FAW:0]   occ_q;
  logic [KW-1:0]  key_rd;
  logic           key_we;
  logic [FAW-1:0] key_raddr;
  logic [SW-1:0]  tot_rd;
  logic           tot_we;
  logic [FAW-1:0] tot_waddr;
  logic [SW-1:0]  tot_wdata;
  logic [FAW-1:0] tot_raddr;
  logic [SW-1:0]  sub_val;
  logic [SW-1:0]  base;
  logic [SW:0]    sum_wide;
  logic [SW-1:0]  sum_sat;
  logic [SW-1:0]  sum_q;
  logic           table_full;
  logic           refused_now;
  logic           create;
  logic           kill;

  // Lookup scan.
  logic [FAW:0]   sidx_q;
  logic [FAW-1:0] cidx_q;
  logic           cvld_q;
  logic           found_q;
  logic [FAW-1:0] fslot_q;
  logic           free_fnd_q;
  logic [FAW-1:0] free_slot_q;

  // Decision.
  wfbr_pkg::status_e status_q;
  logic              new_q;
  logic [FAW-1:0]    cur_slot_q;

  // Ranked row of cells.
  logic [FAW-1:0] cslot_q [FE];
  logic [SW-1:0]  ctot_q  [FE];
  logic [FE-1:0]  cdead_q;
  logic [FAW-1:0] cslot_d [FE];
  logic [SW-1:0]  ctot_d  [FE];
  logic [FE-1:0]  cdead_d;
  logic [FE-1:0]  swp;
  logic           any_swap;
  logic           phase_q;
  logic [1:0]     quiet_q;
  logic           upd_en;
  logic [FAW-1:0] upd_slot;
  logic [SW-1:0]  upd_tot;
  logic           upd_kill;

  // Rank position and report walk.
  logic [FE-1:0]  rvec_q;
  logic [FAW-1:0] rcnt_q;
  logic [7:0]     rank_sat;
  logic [TIW:0]   k_q;
  logic [FAW-1:0] topslot [TNP];
  logic [SW-1:0]  toptot  [TNP];
  int             rep_n;

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  assign tail    = head_q + hcnt_q[HAW-1:0];
  assign hist_we = cmd_i.add;

  wfbr_ram #(.WIDTH(TW), .DEPTH(wfbr_pkg::HIST_DEPTH)) u_hist_time (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (tail),
    .wdata_i (t_q),
    .raddr_i (head_q),
    .rdata_o (ht_rd)
  );

  wfbr_ram #(.WIDTH(FAW + LW), .DEPTH(wfbr_pkg::HIST_DEPTH)) u_hist_flow (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (tail),
    .wdata_i ({cur_slot_q, len_q}),
    .raddr_i (head_q),
    .rdata_o (hs_rd)
  );

  wfbr_ram #(.WIDTH(KW), .DEPTH(FE)) u_key (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (free_slot_q),
    .wdata_i (key_q),
    .raddr_i (key_raddr),
    .rdata_o (key_rd)
  );

  wfbr_ram #(.WIDTH(SW), .DEPTH(FE)) u_total (
    .clk_i   (clk_i),
    .we_i    (tot_we),
    .waddr_i (tot_waddr),
    .wdata_i (tot_wdata),
    .raddr_i (tot_raddr),
    .rdata_o (tot_rd)
  );

  // --------------------------------------------------------------------------
  // Aging and accounting arithmetic
  // --------------------------------------------------------------------------
  assign ret_slot_rd = hs_rd[FAW+LW-1:LW];
  assign ret_len_rd  = hs_rd[LW-1:0];
  assign age_diff    = (t_q >= ht_rd) ? (t_q - ht_rd) : (ht_rd - t_q);
  assign hist_full   = (hcnt_q == (HAW+1)'(wfbr_pkg::HIST_DEPTH));
  assign table_full  = (live_q >= (FAW+1)'(FE));
  assign refused_now = hist_full || (!found_q && table_full);
  assign create      = cmd_i.decide && !refused_now && !found_q;
  assign key_we      = create;

  assign sub_val  = (tot_rd > SW'(ret_len_q)) ? (tot_rd - SW'(ret_len_q)) : '0;
  assign kill     = cmd_i.age_sub && (sub_val == '0);
  assign base     = new_q ? '0 : tot_rd;
  assign sum_wide = {1'b0, base} + (SW+1)'(len_q);
  assign sum_sat  = sum_wide[SW] ? '1 : sum_wide[SW-1:0];

  assign tot_we    = cmd_i.age_sub || cmd_i.add;
  assign tot_waddr = cmd_i.age_sub ? ret_slot_q : cur_slot_q;
  assign tot_wdata = cmd_i.age_sub ? sub_val : sum_sat;
  assign tot_raddr = cmd_i.age_ret ? ret_slot_rd : (found_q ? fslot_q : free_slot_q);

  assign key_raddr = rep_mode_q ? topslot[k_q[TIW-1:0]] : sidx_q[FAW-1:0];

  assign upd_en   = cmd_i.age_sub || cmd_i.add;
  assign upd_slot = cmd_i.age_sub ? ret_slot_q : cur_slot_q;
  assign upd_tot  = cmd_i.age_sub ? sub_val : sum_sat;
  assign upd_kill = kill;

  // --------------------------------------------------------------------------
  // Cell row: compare-exchange network, in-place updates and appends
  // --------------------------------------------------------------------------
  always_comb begin
    swp = '0;
    for (int i = 0; i < FE - 1; i++) begin
      if ((cmd_i.pack_run || cmd_i.sort_run) && (1'(i) == phase_q) &&
          ((FAW+1)'(i + 1) < occ_q)) begin
        // Dead cells sink; in a sort pass live cells also move up past a strictly smaller total.
        swp[i] = !cdead_q[i+1] &&
                 (cdead_q[i] || (cmd_i.sort_run && (ctot_q[i] < ctot_q[i+1])));
      end
    end
  end

  assign any_swap = |swp;

  always_comb begin
    for (int i = 0; i < FE; i++) begin
      cslot_d[i] = cslot_q[i];
      ctot_d[i]  = ctot_q[i];
      cdead_d[i] = cdead_q[i];
      if (swp[i]) begin
        cslot_d[i] = cslot_q[(i + 1) % FE];
        ctot_d[i]  = ctot_q[(i + 1) % FE];
        cdead_d[i] = cdead_q[(i + 1) % FE];
      end else if ((i > 0) && swp[(i + FE - 1) % FE]) begin
        cslot_d[i] = cslot_q[(i + FE - 1) % FE];
        ctot_d[i]  = ctot_q[(i + FE - 1) % FE];
        cdead_d[i] = cdead_q[(i + FE - 1) % FE];
      end else if (upd_en && (cslot_q[i] == upd_slot) && !cdead_q[i] &&
                   ((FAW+1)'(i) < occ_q)) begin
        ctot_d[i]  = upd_tot;
        cdead_d[i] = upd_kill;
      end else if (create && ((FAW+1)'(i) == occ_q)) begin
        cslot_d[i] = free_slot_q;
        ctot_d[i]  = '0;
        cdead_d[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < FE; i++) begin
      cslot_q[i] <= cslot_d[i];
      ctot_q[i]  <= ctot_d[i];
    end
    cdead_q <= cdead_d;
  end

  // Fixed view of the head of the ranked list for reports.
  always_comb begin
    for (int j = 0; j < TNP; j++) begin
      topslot[j] = '0;
      toptot[j]  = '0;
      if ((j < FE) && (j < wfbr_pkg::TOP_N)) begin
        topslot[j] = cslot_q[j % FE];
        toptot[j]  = ctot_q[j % FE];
      end
    end
  end

  always_comb begin
    rep_n = (int'(live_q) < wfbr_pkg::TOP_N) ? int'(live_q) : wfbr_pkg::TOP_N;
  end

  assign rank_sat = (32'(rcnt_q) > 32'd255) ? 8'hFF : 8'(rcnt_q);

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      key_q <= in_data_i[KW-1:0];
      len_q <= in_data_i[KW+LW-1:KW];
      t_q   <= in_data_i[KW+LW+TW-1:KW+LW];
    end
    if (cmd_i.age_ret) begin
      ret_slot_q <= ret_slot_rd;
      ret_len_q  <= ret_len_rd;
    end
    if (cmd_i.decide) begin
      new_q      <= !found_q;
      cur_slot_q <= found_q ? fslot_q : free_slot_q;
    end
    if (cmd_i.add) begin
      sum_q <= sum_sat;
    end
    if (cmd_i.srch_run) begin
      cidx_q <= sidx_q[FAW-1:0];
    end
    if (cmd_i.rank_start) begin
      for (int i = 0; i < FE; i++) begin
        rvec_q[i] <= (cslot_q[i] == cur_slot_q) && !cdead_q[i] &&
                     ((FAW+1)'(i) < occ_q);
      end
    end else if (cmd_i.rank_run && !rvec_q[0]) begin
      rvec_q <= rvec_q >> 1;
    end
    if (cmd_i.out_load) begin
      out_data_o <= {((status_q == wfbr_pkg::ST_COUNTED) ? rank_sat : 8'd0),
                     ((status_q == wfbr_pkg::ST_COUNTED) ? sum_q : '0), key_q};
      out_user_o <= status_q;
      out_last_o <= 1'b1;
    end else if (cmd_i.rep_out) begin
      out_data_o <= {8'(k_q), toptot[k_q[TIW-1:0]], key_rd};
      out_user_o <= wfbr_pkg::ST_REPORT;
      out_last_o <= ((int'(k_q) + 1) == rep_n);
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_mode_q  <= 1'b0;
      head_q      <= '0;
      hcnt_q      <= '0;
      valid_q     <= '0;
      live_q      <= '0;
      occ_q       <= '0;
      sidx_q      <= '0;
      cvld_q      <= 1'b0;
      found_q     <= 1'b0;
      fslot_q     <= '0;
      free_fnd_q  <= 1'b0;
      free_slot_q <= '0;
      status_q    <= wfbr_pkg::ST_COUNTED;
      phase_q     <= 1'b0;
      quiet_q     <= '0;
      rcnt_q      <= '0;
      k_q         <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.latch_in) begin
        rep_mode_q <= in_report_i;
        k_q        <= '0;
      end
      if (cmd_i.age_ret) begin
        head_q <= head_q + 1'b1;
        hcnt_q <= hcnt_q - 1'b1;
      end else if (cmd_i.add) begin
        hcnt_q <= hcnt_q + 1'b1;
      end
      if (kill) begin
        valid_q[ret_slot_q] <= 1'b0;
        live_q              <= live_q - 1'b1;
      end else if (create) begin
        valid_q[free_slot_q] <= 1'b1;
        live_q               <= live_q + 1'b1;
      end
      if (create) begin
        occ_q <= occ_q + 1'b1;
      end else if (cmd_i.sort_fin) begin
        occ_q <= live_q;
      end

      // Lookup scan: one slot issued per cycle, compared in the next cycle.
      if (cmd_i.srch_start) begin
        sidx_q     <= '0;
        cvld_q     <= 1'b0;
        found_q    <= 1'b0;
        free_fnd_q <= 1'b0;
      end else if (cmd_i.srch_run) begin
        if (sidx_q < (FAW+1)'(FE)) begin
          sidx_q <= sidx_q + 1'b1;
          cvld_q <= 1'b1;
          if (!free_fnd_q && !valid_q[sidx_q[FAW-1:0]]) begin
            free_fnd_q  <= 1'b1;
            free_slot_q <= sidx_q[FAW-1:0];
          end
        end else begin
          cvld_q <= 1'b0;
        end
        if (cvld_q && !found_q && valid_q[cidx_q] && (key_rd == key_q)) begin
          found_q <= 1'b1;
          fslot_q <= cidx_q;
        end
      end

      if (cmd_i.decide) begin
        if (hist_full) begin
          status_q <= wfbr_pkg::ST_HIST_FULL;
        end else if (!found_q && table_full) begin
          status_q <= wfbr_pkg::ST_FLOW_FULL;
        end else begin
          status_q <= wfbr_pkg::ST_COUNTED;
        end
      end

      if (cmd_i.sort_start) begin
        phase_q <= 1'b0;
        quiet_q <= '0;
      end else if (cmd_i.pack_run || cmd_i.sort_run) begin
        phase_q <= ~phase_q;
        if (any_swap) begin
          quiet_q <= '0;
        end else if (quiet_q != 2'd2) begin
          quiet_q <= quiet_q + 1'b1;
        end
      end

      if (cmd_i.rank_start) begin
        rcnt_q <= '0;
      end else if (cmd_i.rank_run && !rvec_q[0]) begin
        rcnt_q <= rcnt_q + 1'b1;
      end

      if (cmd_i.rep_out) begin
        k_q <= k_q + 1'b1;
      end

      if (cmd_i.out_load || cmd_i.rep_out) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Status to the controller
  // --------------------------------------------------------------------------
  always_comb begin
    sts_o.hist_empty  = (hcnt_q == '0);
    sts_o.age_expired = (age_diff > TW'(window_i));
    sts_o.ret_valid   = valid_q[ret_slot_rd];
    sts_o.sort_done   = (quiet_q == 2'd2);
    sts_o.srch_done   = found_q || ((sidx_q == (FAW+1)'(FE)) && !cvld_q);
    sts_o.refused     = refused_now;
    sts_o.counted     = (status_q == wfbr_pkg::ST_COUNTED);
    sts_o.rank_done   = rvec_q[0];
    sts_o.rep_empty   = (live_q == '0);
    sts_o.rep_last    = ((int'(k_q) + 1) == rep_n);
    sts_o.out_free    = !out_valid_o || out_ready_i;
  end

endmodule

`default_nettype wire

@@ hdl/windowed_flow_byte_ranker.sv @@
// ----------------------------------------------------------------------------
// windowed_flow_byte_ranker: sliding-window top talker byte counter
// Keeps per-flow byte totals over a time window and ranks the flows.
// ----------------------------------------------------------------------------
// Usage. Request items enter on the s_axis channel; tuser selects an
// accounting request (0) or a report request (1). An accounting item ages
// out history records older than window_us against its timestamp, looks its
// flow up by exact key, adds its length, re-ranks the flows and returns one
// result item with the flow total, its rank and a status. A report item
// returns the highest ranked flows, up to five, with the final one marked
// by tlast; with no live flow it returns nothing.
// Timing. One item is processed at a time. An accounting item retires the
// expired history records one by one, packs the ranked row, scans the key
// memory slot by slot for the lookup (it stops at the matching slot), sorts
// the row, each of the two passes running until no exchange is needed,
// and steps once per rank position above the flow; the key scan over the
// single read port of the key memory usually dominates. A report reads each
// result item and then sends it.
// Reset clears the history, the flow table and the window to 500000 us; no
// memory sweep is needed. The result sits in an output register, so a new
// item is accepted while a result still waits; a stalled receiver only holds
// the block once a further result is ready to go.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_flow_byte_ranker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Request channel. tdata from bit 0 up: src_addr_hi, src_addr_lo,
  // dst_addr_hi, dst_addr_lo, src_port, dst_port, ip_proto, ether_kind,
  // frame_length, arrival_us. tuser: req_type.
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [wfbr_pkg::IN_W-1:0]        s_axis_tdata,
  input  wire logic                             s_axis_tuser,
  // Result channel. tdata from bit 0 up: out_src_hi, out_src_lo, out_dst_hi,
  // out_dst_lo, out_src_port, out_dst_port, out_proto, out_ether,
  // window_bytes, rank. tuser: status. tlast: last.
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic      [wfbr_pkg::OUT_W-1:0]       m_axis_tdata,
  output logic      [1:0]                       m_axis_tuser,
  output logic                                  m_axis_tlast,
  // Register port.
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [wfbr_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [31:0]                      pwdata,
  output logic      [31:0]                      prdata,
  output logic                                  pready
);

  logic [wfbr_pkg::WIN_W-1:0] window_q;
  wfbr_pkg::wfbr_cmd_t        cmd;
  wfbr_pkg::wfbr_sts_t        sts;

  // The window register is written on the access phase of a write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= wfbr_pkg::WINDOW_RESET;
    end else if (psel && penable && pwrite && (paddr == wfbr_pkg::ADDR_WINDOW)) begin
      window_q <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == wfbr_pkg::ADDR_WINDOW) ? window_q : 32'd0;

  wfbr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_report_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wfbr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .window_i    (window_q),
    .in_data_i   (s_axis_tdata),
    .in_report_i (s_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire
